// ----- sv/radix_literal_to_integer_unit_defines.svh -----
// Assertion macros used by the number literal converter RTL.
`ifndef RADIX_LITERAL_TO_INTEGER_UNIT_DEFINES_SVH
`define RADIX_LITERAL_TO_INTEGER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define RLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

`define RLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`else

`define RLI_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define RLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- sv/rli_pkg.sv -----
// Types and constants of the number literal converter.
`timescale 1ns / 1ps

package rli_pkg;

    localparam int OUT_VALUE_W = 32;
    localparam int COUNT_W     = 16;

    localparam logic [1:0] BASE_HEX = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_OCT = 2'd2;
    localparam logic [1:0] BASE_BIN = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] ALPHA_OFFSET = 8'd87;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] base_kind;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [OUT_VALUE_W-1:0] value;
        logic [COUNT_W-1:0]     length;
        logic                   suffix_taken;
    } t_out_item;

endpackage

// ----- sv/radix_literal_to_integer_unit.sv -----
// Top level of the streaming number literal converter.
//
// Characters of an assembler number literal arrive one per item on the input
// channel, with start_req set on the first character and base_kind giving the
// base (hex, decimal, octal or binary) for the new literal.
// The literal ends on the first character that is not a digit or prefix letter;
// a suffix letter ends it as well and is counted. That item gives one result
// item with the value, the character count and whether a suffix was consumed.
// Each item is handled by the parse logic in front of the literal state
// registers; a result appears on the output channel in the cycle after the
// item that ends the literal is accepted.
// Throughput is one character per cycle, limited only by the single output
// register; while that register holds an untaken result and the receiver
// keeps ready low, input ready is low as well.
// Reset clears the literal state and empties the output register.
`timescale 1ns / 1ps

`include "radix_literal_to_integer_unit_defines.svh"

module radix_literal_to_integer_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rli_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rli_pkg::t_out_item o_out_item
);

    import rli_pkg::*;

    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic [COUNT_W-1:0]    r_count,  n_count;
    logic [1:0]            r_base,   n_base;
    logic                  r_active, n_active;
    logic                  r_prefix, n_prefix;
    logic                  r_fwz,    n_fwz;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item,  n_out_item;

    logic                  in_acc;
    logic                  eff_active;
    logic [VALUE_BITS-1:0] cur_acc;
    logic [COUNT_W-1:0]    cur_count;
    logic [COUNT_W-1:0]    bumped_count;
    logic [1:0]            cur_base;
    logic                  cur_prefix;
    logic                  cur_fwz;
    logic [7:0]            lc;
    logic                  digit_hit;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] scaled;
    logic                  is_prefix;
    logic                  is_suffix;
    logic                  feed_end;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        eff_active = i_in_item.start_req || r_active;
        cur_acc    = i_in_item.start_req ? '0 : r_acc;
        cur_count  = i_in_item.start_req ? '0 : r_count;
        cur_base   = i_in_item.start_req ? i_in_item.base_kind : r_base;
        cur_prefix = i_in_item.start_req ? 1'b0 : r_prefix;
        cur_fwz    = i_in_item.start_req ? 1'b0 : r_fwz;

        bumped_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;

        if (i_in_item.ch inside {[CH_UP_A:CH_UP_Z]}) begin
            lc = i_in_item.ch + CASE_OFFSET;
        end else begin
            lc = i_in_item.ch;
        end

        digit_hit = 1'b0;
        digit     = 4'(i_in_item.ch - CH_ZERO);
        case (cur_base)
            BASE_HEX: begin
                if (i_in_item.ch inside {[CH_ZERO:CH_NINE]}) begin
                    digit_hit = 1'b1;
                end else if (lc inside {[CH_LO_A:CH_LO_F]}) begin
                    digit_hit = 1'b1;
                    digit     = 4'(lc - ALPHA_OFFSET);
                end
            end
            BASE_DEC: digit_hit = i_in_item.ch inside {[CH_ZERO:CH_NINE]};
            BASE_OCT: digit_hit = i_in_item.ch inside {[CH_ZERO:CH_SEVEN]};
            default:  digit_hit = i_in_item.ch inside {[CH_ZERO:CH_ONE]};
        endcase

        case (cur_base)
            BASE_HEX: scaled = cur_acc << 4;
            BASE_DEC: scaled = (cur_acc << 3) + (cur_acc << 1);
            BASE_OCT: scaled = cur_acc << 3;
            default:  scaled = cur_acc << 1;
        endcase

        is_prefix = !digit_hit && !cur_prefix && (cur_count == COUNT_W'(1)) && cur_fwz &&
                    (((cur_base == BASE_HEX) && (lc == CH_LO_X)) ||
                     ((cur_base == BASE_BIN) && (lc == CH_LO_B)));
        is_suffix = !digit_hit && !is_prefix && !cur_prefix &&
                    (((cur_base == BASE_HEX) && (lc == CH_LO_H)) ||
                     ((cur_base == BASE_BIN) && (lc == CH_LO_B)));
        feed_end  = !digit_hit && !is_prefix;

        n_acc    = r_acc;
        n_count  = r_count;
        n_base   = r_base;
        n_active = r_active;
        n_prefix = r_prefix;
        n_fwz    = r_fwz;

        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;

        if (in_acc && eff_active) begin
            n_base   = cur_base;
            n_acc    = cur_acc;
            n_count  = cur_count;
            n_prefix = cur_prefix;
            n_fwz    = cur_fwz;
            n_active = !feed_end;
            if (digit_hit) begin
                n_acc   = scaled + VALUE_BITS'(digit);
                n_count = bumped_count;
                if (cur_count == '0) begin
                    n_fwz = (i_in_item.ch == CH_ZERO);
                end
            end else if (is_prefix) begin
                n_prefix = 1'b1;
                n_count  = bumped_count;
            end else if (is_suffix) begin
                n_count = bumped_count;
            end

            if (i_in_item.start_req && r_active) begin
                n_out_valid             = 1'b1;
                n_out_item.value        = OUT_VALUE_W'(r_acc);
                n_out_item.length       = r_count;
                n_out_item.suffix_taken = 1'b0;
            end else if (feed_end) begin
                n_out_valid             = 1'b1;
                n_out_item.value        = OUT_VALUE_W'(cur_acc);
                n_out_item.length       = is_suffix ? bumped_count : cur_count;
                n_out_item.suffix_taken = is_suffix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_count     <= '0;
            r_base      <= BASE_HEX;
            r_active    <= 1'b0;
            r_prefix    <= 1'b0;
            r_fwz       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_count     <= n_count;
            r_base      <= n_base;
            r_active    <= n_active;
            r_prefix    <= n_prefix;
            r_fwz       <= n_fwz;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `RLI_ASSERT_NEXT(a_start_count, i_clk, i_rst_n, in_acc && i_in_item.start_req, r_count <= COUNT_W'(1))
    `RLI_ASSERT_NEXT(a_idle_stays, i_clk, i_rst_n, in_acc && !i_in_item.start_req && !r_active, !r_active)
    `RLI_ASSERT_IMP(a_prefix_count, i_clk, i_rst_n, r_prefix, r_count >= COUNT_W'(2))
    `RLI_ASSERT_NEXT(a_restart_emits, i_clk, i_rst_n, in_acc && i_in_item.start_req && r_active, r_out_valid)

endmodule
